/* src/bsd_pkg.sv */
package bsd_pkg;

	// Parameter defaults
	localparam int MAX_GROUP_DEF  = 1024;
	localparam int VALUE_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF  = 8;

	// Fixed field widths
	localparam int TIME_W   = 32;
	localparam int SVAL_W   = 16;
	localparam int GSIZE_W  = 11;
	localparam int MTIME_W  = 40;
	localparam int RES_W    = 24;

	// Group size after reset
	localparam logic [GSIZE_W-1:0] GSIZE_RESET = 11'd16;

	// Q8.16 fractions
	localparam int FRAC_SHIFT = 16;
	localparam logic [RES_W-1:0] FRACTION_ONE = 24'd65536;

	// Group record queue depth (power of two)
	localparam int QUEUE_DEPTH = 2;

	// Back end sequencer
	typedef enum logic [2:0] {
		BK_IDLE,
		BK_MUL,
		BK_DIFF,
		BK_SQ_GO,
		BK_SQ_WAIT,
		BK_DV_GO,
		BK_DV_WAIT,
		BK_DONE
	} bk_state_t;

	// Division order; zero sum stops at POIS
	typedef enum logic [2:0] {
		OP_TIME,
		OP_VALUE,
		OP_RMS,
		OP_POIS,
		OP_RFRAC,
		OP_SPREAD
	} div_op_t;

endpackage

/* src/bsd_front.sv */
module bsd_front #(
	parameter int MAX_GROUP  = bsd_pkg::MAX_GROUP_DEF,
	parameter int VALUE_BITS = bsd_pkg::VALUE_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [bsd_pkg::GSIZE_W-1:0] cfg_wdata,
	input  logic in_valid,
	output logic in_ready,
	input  logic [bsd_pkg::TIME_W-1:0] sample_time,
	input  logic [bsd_pkg::SVAL_W-1:0] sample_value,
	output logic push_valid,
	input  logic push_ready,
	output logic [$clog2(MAX_GROUP+1)-1:0] push_n,
	output logic [bsd_pkg::TIME_W+$clog2(MAX_GROUP)-1:0] push_tsum,
	output logic [((VALUE_BITS < bsd_pkg::SVAL_W) ? VALUE_BITS : bsd_pkg::SVAL_W)
		+$clog2(MAX_GROUP)-1:0] push_vsum,
	output logic [2*((VALUE_BITS < bsd_pkg::SVAL_W) ? VALUE_BITS : bsd_pkg::SVAL_W)
		+$clog2(MAX_GROUP)-1:0] push_qsum,
	output logic [((VALUE_BITS < bsd_pkg::SVAL_W) ? VALUE_BITS : bsd_pkg::SVAL_W)-1:0]
		push_range
);

	localparam int LG    = $clog2(MAX_GROUP);
	localparam int CNT_W = $clog2(MAX_GROUP+1);
	localparam int VB    = (VALUE_BITS < bsd_pkg::SVAL_W) ? VALUE_BITS : bsd_pkg::SVAL_W;
	localparam int TS_W  = bsd_pkg::TIME_W + LG;
	localparam int VS_W  = VB + LG;
	localparam int QS_W  = 2*VB + LG;

	logic [bsd_pkg::GSIZE_W-1:0] group_size_q;
	logic [CNT_W-1:0] fill_q;
	logic [TS_W-1:0]  tsum_q;
	logic [VS_W-1:0]  vsum_q;
	logic [QS_W-1:0]  qsum_q;
	logic [VB-1:0]    max_q;
	logic [VB-1:0]    min_q;

	logic [31:0]      gs_ext;
	logic [CNT_W-1:0] target;
	logic [CNT_W-1:0] fill_nx;
	logic             complete;
	logic             accept;
	logic [VB-1:0]    v;
	logic [2*VB-1:0]  sq;
	logic [TS_W-1:0]  tsum_nx;
	logic [VS_W-1:0]  vsum_nx;
	logic [QS_W-1:0]  qsum_nx;
	logic [VB-1:0]    max_nx;
	logic [VB-1:0]    min_nx;

	// Effective group size: zero means one, clamp at MAX_GROUP
	always_comb begin
		gs_ext = 32'(group_size_q);
		if (gs_ext == 32'd0) begin
			target = CNT_W'(1);
		end else if (gs_ext > 32'(MAX_GROUP)) begin
			target = CNT_W'(MAX_GROUP);
		end else begin
			target = CNT_W'(gs_ext);
		end
	end

	// Accumulate the new sample
	always_comb begin
		v        = sample_value[VB-1:0];
		sq       = (2*VB)'(v) * (2*VB)'(v);
		fill_nx  = fill_q + CNT_W'(1);
		tsum_nx  = tsum_q + TS_W'(sample_time);
		vsum_nx  = vsum_q + VS_W'(v);
		qsum_nx  = qsum_q + QS_W'(sq);
		max_nx   = (v > max_q) ? v : max_q;
		min_nx   = (v < min_q) ? v : min_q;
		complete = (fill_nx >= target);
	end

	// Stall only when the closing sample finds the queue full
	assign in_ready   = !complete || push_ready;
	assign accept     = in_valid && in_ready;
	assign push_valid = in_valid && complete;
	assign push_n     = fill_nx;
	assign push_tsum  = tsum_nx;
	assign push_vsum  = vsum_nx;
	assign push_qsum  = qsum_nx;
	assign push_range = max_nx - min_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_size_q <= bsd_pkg::GSIZE_RESET;
			fill_q       <= '0;
			tsum_q       <= '0;
			vsum_q       <= '0;
			qsum_q       <= '0;
			max_q        <= '0;
			min_q        <= '1;
		end else begin
			if (cfg_we) begin
				group_size_q <= cfg_wdata;
			end
			if (accept) begin
				if (complete) begin
					fill_q <= '0;
					tsum_q <= '0;
					vsum_q <= '0;
					qsum_q <= '0;
					max_q  <= '0;
					min_q  <= '1;
				end else begin
					fill_q <= fill_nx;
					tsum_q <= tsum_nx;
					vsum_q <= vsum_nx;
					qsum_q <= qsum_nx;
					max_q  <= max_nx;
					min_q  <= min_nx;
				end
			end
		end
	end

endmodule

/* src/bsd_queue.sv */
module bsd_queue #(
	parameter int W = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  logic [W-1:0] push_data,
	output logic pop_valid,
	input  logic pop_ready,
	output logic [W-1:0] pop_data
);

	localparam int DEPTH = bsd_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH+1);

	logic [W-1:0]     entry_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entry_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_q] <= push_data;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

/* src/bsd_sqrt.sv */
module bsd_sqrt #(
	parameter int SQ_W = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [SQ_W-1:0] radicand,
	output logic done,
	output logic [SQ_W/2-1:0] root
);

	localparam int RT_W  = SQ_W/2;
	localparam int CNT_W = $clog2(RT_W+1);

	logic [SQ_W-1:0]   x_q;
	logic [RT_W-1:0]   root_q;
	logic [RT_W-1:0]   rem_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [RT_W+1:0]   r2;
	logic [RT_W+1:0]   trial;
	logic [RT_W+1:0]   rem_nx;
	logic              ge;

	// One root bit per cycle, two radicand bits in
	// (the remainder fits RT_W bits until the last step, whose remainder is dropped)
	always_comb begin
		r2     = {rem_q, x_q[SQ_W-1 -: 2]};
		trial  = {root_q, 2'b01};
		ge     = (r2 >= trial);
		rem_nx = ge ? (r2 - trial) : r2;
	end

	assign done = done_q;
	assign root = root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(RT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= radicand;
			root_q <= '0;
			rem_q  <= '0;
		end else if (busy_q) begin
			x_q    <= {x_q[SQ_W-3:0], 2'b00};
			rem_q  <= rem_nx[RT_W-1:0];
			root_q <= {root_q[RT_W-2:0], ge};
		end
	end

endmodule

/* src/bsd_div.sv */
module bsd_div #(
	parameter int DN_W = 8,
	parameter int DD_W = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [DN_W-1:0] num,
	input  logic [DD_W-1:0] den,
	output logic done,
	output logic [DN_W-1:0] quo
);

	localparam int CNT_W = $clog2(DN_W+1);

	logic [DN_W-1:0]  q_q;
	logic [DD_W-1:0]  rem_q;
	logic [DD_W-1:0]  den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DD_W:0]    r2;
	logic [DD_W-1:0]  diff;
	logic             ge;

	// Restoring division, one quotient bit per cycle
	always_comb begin
		r2   = {rem_q, q_q[DN_W-1]};
		diff = r2[DD_W-1:0] - den_q;
		ge   = (r2 >= {1'b0, den_q});
	end

	assign done = done_q;
	assign quo  = q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DN_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff : r2[DD_W-1:0];
			q_q   <= {q_q[DN_W-2:0], ge};
		end
	end

endmodule

/* src/bsd_back.sv */
module bsd_back #(
	parameter int MAX_GROUP  = bsd_pkg::MAX_GROUP_DEF,
	parameter int VALUE_BITS = bsd_pkg::VALUE_BITS_DEF,
	parameter int FRAC_BITS  = bsd_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic rec_valid,
	output logic rec_ready,
	input  logic [$clog2(MAX_GROUP+1)-1:0] rec_n,
	input  logic [bsd_pkg::TIME_W+$clog2(MAX_GROUP)-1:0] rec_tsum,
	input  logic [((VALUE_BITS < bsd_pkg::SVAL_W) ? VALUE_BITS : bsd_pkg::SVAL_W)
		+$clog2(MAX_GROUP)-1:0] rec_vsum,
	input  logic [2*((VALUE_BITS < bsd_pkg::SVAL_W) ? VALUE_BITS : bsd_pkg::SVAL_W)
		+$clog2(MAX_GROUP)-1:0] rec_qsum,
	input  logic [((VALUE_BITS < bsd_pkg::SVAL_W) ? VALUE_BITS : bsd_pkg::SVAL_W)-1:0]
		rec_range,
	output logic out_valid,
	input  logic out_ready,
	output logic [bsd_pkg::MTIME_W-1:0] mean_time,
	output logic [bsd_pkg::RES_W-1:0] mean_value,
	output logic [bsd_pkg::RES_W-1:0] rms_value,
	output logic [bsd_pkg::RES_W-1:0] poisson_error,
	output logic [bsd_pkg::RES_W-1:0] rms_fraction,
	output logic [bsd_pkg::RES_W-1:0] spread_fraction
);

	localparam int LG    = $clog2(MAX_GROUP);
	localparam int CNT_W = $clog2(MAX_GROUP+1);
	localparam int VB    = (VALUE_BITS < bsd_pkg::SVAL_W) ? VALUE_BITS : bsd_pkg::SVAL_W;
	localparam int TS_W  = bsd_pkg::TIME_W + LG;
	localparam int VS_W  = VB + LG;
	localparam int QS_W  = 2*VB + LG;
	localparam int D_W   = QS_W + CNT_W;
	localparam int FS    = bsd_pkg::FRAC_SHIFT;
	localparam int SQ_W  = ((D_W + 2*FS + 1)/2)*2;
	localparam int RT_W  = SQ_W/2;
	localparam int RSH   = FS - FRAC_BITS;
	localparam int SP_W  = VB + CNT_W + FS;
	localparam int NA_W  = (TS_W > VS_W) ? TS_W + FRAC_BITS : VS_W + FRAC_BITS;
	localparam int NB_W  = (RT_W > SP_W) ? RT_W : SP_W;
	localparam int DN_W  = (NA_W > NB_W) ? NA_W : NB_W;
	localparam int DD_W  = (CNT_W > VS_W) ? CNT_W : VS_W;
	localparam int MT_W  = bsd_pkg::MTIME_W;
	localparam int R_W   = bsd_pkg::RES_W;
	localparam int QX_W  = DN_W + MT_W;

	bsd_pkg::bk_state_t state_q, state_nx;
	bsd_pkg::div_op_t   op_q;

	logic [CNT_W-1:0] n_q;
	logic [TS_W-1:0]  tsum_q;
	logic [VS_W-1:0]  vsum_q;
	logic [QS_W-1:0]  qsum_q;
	logic [VB-1:0]    range_q;
	logic [D_W-1:0]   nq_q;
	logic [D_W-1:0]   ss_q;
	logic [SP_W-1:0]  spr_q;
	logic [D_W-1:0]   d_q;
	logic [RT_W-1:0]  rootd_q;
	logic [RT_W-1:0]  roots_q;
	logic             sq_op_q;

	logic [MT_W-1:0]  r_time_q;
	logic [R_W-1:0]   r_val_q;
	logic [R_W-1:0]   r_rms_q;
	logic [R_W-1:0]   r_pois_q;
	logic [R_W-1:0]   r_rf_q;
	logic [R_W-1:0]   r_sp_q;

	logic             out_valid_q;
	logic [MT_W-1:0]  mean_time_q;
	logic [R_W-1:0]   mean_value_q;
	logic [R_W-1:0]   rms_value_q;
	logic [R_W-1:0]   poisson_error_q;
	logic [R_W-1:0]   rms_fraction_q;
	logic [R_W-1:0]   spread_fraction_q;

	logic             sq_start;
	logic             sq_done;
	logic [SQ_W-1:0]  sq_rad;
	logic [RT_W-1:0]  sq_root;
	logic             dv_start;
	logic             dv_done;
	logic [DN_W-1:0]  dv_num;
	logic [DD_W-1:0]  dv_den;
	logic [DN_W-1:0]  dv_quo;
	logic [QX_W-1:0]  qx;
	logic [MT_W-1:0]  sat40;
	logic [R_W-1:0]   sat24;
	logic             load_out;

	// Shared square root: D then S, both scaled by 2^32
	bsd_sqrt #(.SQ_W(SQ_W)) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (sq_rad),
		.done     (sq_done),
		.root     (sq_root)
	);

	// Shared divider for all six results
	bsd_div #(.DN_W(DN_W), .DD_W(DD_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dv_start),
		.num    (dv_num),
		.den    (dv_den),
		.done   (dv_done),
		.quo    (dv_quo)
	);

	assign sq_rad = sq_op_q ? (SQ_W'(vsum_q) << (2*FS)) : (SQ_W'(d_q) << (2*FS));

	// Divider operands per step
	always_comb begin
		case (op_q)
			bsd_pkg::OP_TIME: begin
				dv_num = DN_W'(tsum_q) << FRAC_BITS;
				dv_den = DD_W'(n_q);
			end
			bsd_pkg::OP_VALUE: begin
				dv_num = DN_W'(vsum_q) << FRAC_BITS;
				dv_den = DD_W'(n_q);
			end
			bsd_pkg::OP_RMS: begin
				dv_num = DN_W'(rootd_q >> RSH);
				dv_den = DD_W'(n_q);
			end
			bsd_pkg::OP_POIS: begin
				dv_num = DN_W'(roots_q >> RSH);
				dv_den = DD_W'(n_q);
			end
			bsd_pkg::OP_RFRAC: begin
				dv_num = DN_W'(rootd_q);
				dv_den = DD_W'(vsum_q);
			end
			bsd_pkg::OP_SPREAD: begin
				dv_num = DN_W'(spr_q);
				dv_den = DD_W'(vsum_q);
			end
			default: begin
				dv_num = '0;
				dv_den = DD_W'(n_q);
			end
		endcase
	end

	// Saturate the quotient to the result fields
	always_comb begin
		qx    = QX_W'(dv_quo);
		sat40 = (|qx[QX_W-1:MT_W]) ? '1 : qx[MT_W-1:0];
		sat24 = (|qx[QX_W-1:R_W]) ? '1 : qx[R_W-1:0];
	end

	// Sequencer: next state and unit requests
	always_comb begin
		state_nx  = state_q;
		rec_ready = 1'b0;
		sq_start  = 1'b0;
		dv_start  = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			bsd_pkg::BK_IDLE: begin
				rec_ready = 1'b1;
				if (rec_valid) begin
					state_nx = bsd_pkg::BK_MUL;
				end
			end
			bsd_pkg::BK_MUL: begin
				state_nx = bsd_pkg::BK_DIFF;
			end
			bsd_pkg::BK_DIFF: begin
				state_nx = bsd_pkg::BK_SQ_GO;
			end
			bsd_pkg::BK_SQ_GO: begin
				sq_start = 1'b1;
				state_nx = bsd_pkg::BK_SQ_WAIT;
			end
			bsd_pkg::BK_SQ_WAIT: begin
				if (sq_done) begin
					state_nx = sq_op_q ? bsd_pkg::BK_DV_GO : bsd_pkg::BK_SQ_GO;
				end
			end
			bsd_pkg::BK_DV_GO: begin
				dv_start = 1'b1;
				state_nx = bsd_pkg::BK_DV_WAIT;
			end
			bsd_pkg::BK_DV_WAIT: begin
				if (dv_done) begin
					if (op_q == bsd_pkg::OP_SPREAD ||
						(op_q == bsd_pkg::OP_POIS && vsum_q == '0)) begin
						state_nx = bsd_pkg::BK_DONE;
					end else begin
						state_nx = bsd_pkg::BK_DV_GO;
					end
				end
			end
			bsd_pkg::BK_DONE: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_nx = bsd_pkg::BK_IDLE;
				end
			end
			default: begin
				state_nx = bsd_pkg::BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bsd_pkg::BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		case (state_q)
			bsd_pkg::BK_IDLE: begin
				n_q     <= rec_n;
				tsum_q  <= rec_tsum;
				vsum_q  <= rec_vsum;
				qsum_q  <= rec_qsum;
				range_q <= rec_range;
			end
			bsd_pkg::BK_MUL: begin
				nq_q  <= D_W'(n_q) * D_W'(qsum_q);
				ss_q  <= D_W'(vsum_q) * D_W'(vsum_q);
				spr_q <= (SP_W'(range_q) * SP_W'(n_q)) << FS;
			end
			bsd_pkg::BK_DIFF: begin
				d_q     <= (nq_q >= ss_q) ? (nq_q - ss_q) : '0;
				sq_op_q <= 1'b0;
			end
			bsd_pkg::BK_SQ_WAIT: begin
				if (sq_done) begin
					if (sq_op_q) begin
						roots_q <= sq_root;
						op_q    <= bsd_pkg::OP_TIME;
					end else begin
						rootd_q <= sq_root;
						sq_op_q <= 1'b1;
					end
				end
			end
			bsd_pkg::BK_DV_WAIT: begin
				if (dv_done) begin
					case (op_q)
						bsd_pkg::OP_TIME: begin
							r_time_q <= sat40;
							op_q     <= bsd_pkg::OP_VALUE;
						end
						bsd_pkg::OP_VALUE: begin
							r_val_q <= sat24;
							op_q    <= bsd_pkg::OP_RMS;
						end
						bsd_pkg::OP_RMS: begin
							r_rms_q <= sat24;
							op_q    <= bsd_pkg::OP_POIS;
						end
						bsd_pkg::OP_POIS: begin
							r_pois_q <= sat24;
							op_q     <= bsd_pkg::OP_RFRAC;
							// zero mean: both fractions read 1.0
							r_rf_q   <= bsd_pkg::FRACTION_ONE;
							r_sp_q   <= bsd_pkg::FRACTION_ONE;
						end
						bsd_pkg::OP_RFRAC: begin
							r_rf_q <= sat24;
							op_q   <= bsd_pkg::OP_SPREAD;
						end
						bsd_pkg::OP_SPREAD: begin
							r_sp_q <= sat24;
						end
						default: begin
							op_q <= bsd_pkg::OP_TIME;
						end
					endcase
				end
			end
			default: begin
			end
		endcase
	end

	// Output register
	always_ff @(posedge clk) begin
		if (load_out) begin
			mean_time_q       <= r_time_q;
			mean_value_q      <= r_val_q;
			rms_value_q       <= r_rms_q;
			poisson_error_q   <= r_pois_q;
			rms_fraction_q    <= r_rf_q;
			spread_fraction_q <= r_sp_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign mean_time       = mean_time_q;
	assign mean_value      = mean_value_q;
	assign rms_value       = rms_value_q;
	assign poisson_error   = poisson_error_q;
	assign rms_fraction    = rms_fraction_q;
	assign spread_fraction = spread_fraction_q;

endmodule

/* src/block_stats_decimator.sv */
// Channel   Handshake                Payload
// config    cfg_we                   cfg_wdata (group size)
// samples   in_valid / in_ready      sample_time, sample_value
// results   out_valid / out_ready    mean_time .. spread_fraction
//
// The front end takes one sample per cycle; it stalls only when the sample
// that closes a group finds the two-entry group queue full.
// The back end handles one group at a time, using the bit-serial square root
// (RT root bits) and divider (DN quotient bits); it takes the next group
// record only when it is back in idle.
// Reset is asynchronous, active low; no clearing pass is needed.
module block_stats_decimator #(
	parameter int MAX_GROUP  = bsd_pkg::MAX_GROUP_DEF,
	parameter int VALUE_BITS = bsd_pkg::VALUE_BITS_DEF,
	parameter int FRAC_BITS  = bsd_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [bsd_pkg::GSIZE_W-1:0] cfg_wdata,
	input  logic in_valid,
	output logic in_ready,
	input  logic [bsd_pkg::TIME_W-1:0] sample_time,
	input  logic [bsd_pkg::SVAL_W-1:0] sample_value,
	output logic out_valid,
	input  logic out_ready,
	output logic [bsd_pkg::MTIME_W-1:0] mean_time,
	output logic [bsd_pkg::RES_W-1:0] mean_value,
	output logic [bsd_pkg::RES_W-1:0] rms_value,
	output logic [bsd_pkg::RES_W-1:0] poisson_error,
	output logic [bsd_pkg::RES_W-1:0] rms_fraction,
	output logic [bsd_pkg::RES_W-1:0] spread_fraction
);

	localparam int LG    = $clog2(MAX_GROUP);
	localparam int CNT_W = $clog2(MAX_GROUP+1);
	localparam int VB    = (VALUE_BITS < bsd_pkg::SVAL_W) ? VALUE_BITS : bsd_pkg::SVAL_W;
	localparam int TS_W  = bsd_pkg::TIME_W + LG;
	localparam int VS_W  = VB + LG;
	localparam int QS_W  = 2*VB + LG;
	localparam int REC_W = CNT_W + TS_W + VS_W + QS_W + VB;

	logic             push_valid;
	logic             push_ready;
	logic [CNT_W-1:0] push_n;
	logic [TS_W-1:0]  push_tsum;
	logic [VS_W-1:0]  push_vsum;
	logic [QS_W-1:0]  push_qsum;
	logic [VB-1:0]    push_range;
	logic [REC_W-1:0] push_data;
	logic             rec_valid;
	logic             rec_ready;
	logic [REC_W-1:0] rec_data;

	bsd_front #(
		.MAX_GROUP  (MAX_GROUP),
		.VALUE_BITS (VALUE_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sample_time  (sample_time),
		.sample_value (sample_value),
		.push_valid   (push_valid),
		.push_ready   (push_ready),
		.push_n       (push_n),
		.push_tsum    (push_tsum),
		.push_vsum    (push_vsum),
		.push_qsum    (push_qsum),
		.push_range   (push_range)
	);

	assign push_data = {push_n, push_tsum, push_vsum, push_qsum, push_range};

	bsd_queue #(.W(REC_W)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (rec_valid),
		.pop_ready  (rec_ready),
		.pop_data   (rec_data)
	);

	bsd_back #(
		.MAX_GROUP  (MAX_GROUP),
		.VALUE_BITS (VALUE_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.rec_valid       (rec_valid),
		.rec_ready       (rec_ready),
		.rec_n           (rec_data[REC_W-1 -: CNT_W]),
		.rec_tsum        (rec_data[REC_W-CNT_W-1 -: TS_W]),
		.rec_vsum        (rec_data[VB+QS_W+VS_W-1 -: VS_W]),
		.rec_qsum        (rec_data[VB+QS_W-1 -: QS_W]),
		.rec_range       (rec_data[VB-1:0]),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.mean_time       (mean_time),
		.mean_value      (mean_value),
		.rms_value       (rms_value),
		.poisson_error   (poisson_error),
		.rms_fraction    (rms_fraction),
		.spread_fraction (spread_fraction)
	);

endmodule

/* src/bsd_checker.sv */
module bsd_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic [bsd_pkg::MTIME_W-1:0] mean_time,
	input logic [bsd_pkg::RES_W-1:0] mean_value,
	input logic [bsd_pkg::RES_W-1:0] poisson_error,
	input logic [bsd_pkg::RES_W-1:0] rms_fraction
);

	// A stalled result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result request dropped while stalled");

	// A stalled result keeps its checked fields
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(mean_time) && $stable(mean_value) &&
			$stable(rms_fraction))
		else $error("result fields changed while stalled");

	// sqrt(S)/n never exceeds S/n for integer S
	a_pois_le_mean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> poisson_error <= mean_value)
		else $error("poisson error above mean value");

endmodule

bind block_stats_decimator bsd_checker u_bsd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.mean_time     (mean_time),
	.mean_value    (mean_value),
	.poisson_error (poisson_error),
	.rms_fraction  (rms_fraction)
);
